// ===== sv/pzd_pkg.sv =====
// ----------------------------------------------------------------------------
// pzd_pkg
// Shared constants and types for the packed/zoned decimal decoder: sign
// nibble codes, result status codes and the sign decode bundle.
// ----------------------------------------------------------------------------
package pzd_pkg;

   localparam int MagW = 63;
   localparam int ValW = 64;
   // Wide enough for acc*100 + 99-ish digit terms without wrap
   localparam int SumW = 70;

   localparam logic [MagW-1:0] MAG_MAX = {MagW{1'b1}};

   // Sign nibbles
   localparam logic [3:0] SIGN_PACKED_PLUS = 4'hC;
   localparam logic [3:0] SIGN_MINUS       = 4'hD;
   localparam logic [3:0] SIGN_PLUS_F      = 4'hF;
   localparam logic [3:0] SIGN_ZONED_MINUS = 4'hB;

   // Byte encoding selector
   localparam logic ENC_PACKED = 1'b0;
   localparam logic ENC_ZONED  = 1'b1;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_BAD_SIGN = 2'd1,
      ST_OVERFLOW = 2'd2
   } status_type;

   typedef struct packed {
      logic valid;
      logic minus;
   } sign_info_type;

endpackage

// ===== sv/pzd_digit_acc.sv =====
// ----------------------------------------------------------------------------
// pzd_digit_acc
// Saturating decimal accumulate: folds one or two digit nibbles of a byte
// into the running magnitude (acc*10+d or acc*100+hi*10+lo).
// ----------------------------------------------------------------------------
module pzd_digit_acc
   import pzd_pkg::*;
(
   input  logic [MagW-1:0] acc,
   input  logic            ovf,
   input  logic            zoned,
   input  logic [7:0]      data_byte,
   input  logic            last_byte,
   output logic [MagW-1:0] acc_nxt,
   output logic            ovf_nxt
);

   logic [3:0]      hi;
   logic [3:0]      lo;
   logic [3:0]      digit;
   logic [SumW-1:0] acc_w;
   logic [SumW-1:0] sum_one;
   logic [SumW-1:0] sum_two;
   logic [SumW-1:0] sum;
   logic            two_digits;
   logic            too_big;

   assign hi    = data_byte[7:4];
   assign lo    = data_byte[3:0];
   assign acc_w = {{(SumW-MagW){1'b0}}, acc};

   // Zoned bytes give the low nibble; a packed last byte gives only the high
   assign digit      = zoned ? lo : hi;
   assign two_digits = !zoned && !last_byte;

   // Multiply by constants as shift-and-add
   assign sum_one = (acc_w << 3) + (acc_w << 1) + {{(SumW-4){1'b0}}, digit};
   assign sum_two = (acc_w << 6) + (acc_w << 5) + (acc_w << 2)
                  + ({{(SumW-4){1'b0}}, hi} << 3) + ({{(SumW-4){1'b0}}, hi} << 1)
                  + {{(SumW-4){1'b0}}, lo};

   // Sums only grow, so two steps overflow iff the combined sum does
   assign sum     = two_digits ? sum_two : sum_one;
   assign too_big = |sum[SumW-1:MagW];

   // Saturate and stick once overflowed
   always_comb begin
      if (ovf || too_big) begin
         acc_nxt = MAG_MAX;
         ovf_nxt = 1'b1;
      end else begin
         acc_nxt = sum[MagW-1:0];
         ovf_nxt = 1'b0;
      end
   end

endmodule

// ===== sv/pzd_sign_dec.sv =====
// ----------------------------------------------------------------------------
// pzd_sign_dec
// Sign nibble decode for the last byte of a field, per encoding.
// ----------------------------------------------------------------------------
module pzd_sign_dec
   import pzd_pkg::*;
(
   input  logic          zoned,
   input  logic [7:0]    data_byte,
   output sign_info_type sign_info
);

   logic [3:0] nib;

   // Zoned carries the sign in the zone nibble, packed in the low nibble
   assign nib = zoned ? data_byte[7:4] : data_byte[3:0];

   always_comb begin
      if (zoned) begin
         sign_info.minus = (nib == SIGN_MINUS) || (nib == SIGN_ZONED_MINUS);
         sign_info.valid = sign_info.minus || (nib == SIGN_PLUS_F);
      end else begin
         sign_info.minus = (nib == SIGN_MINUS);
         sign_info.valid = sign_info.minus || (nib == SIGN_PACKED_PLUS)
                         || (nib == SIGN_PLUS_F);
      end
   end

endmodule

// ===== sv/packed_zoned_decimal_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// packed_zoned_decimal_decoder_unit
// Decodes packed (COMP-3) and zoned decimal fields, one byte per item, into
// saturated 64-bit signed integers.
// ----------------------------------------------------------------------------
// Takes one field byte per cycle with no bubbles; an item passes an input
// register, then one accumulate step into the result register, from which a
// field's result is offered once its last byte has passed both. Only the byte marked
// tlast produces a result; earlier bytes just fold their digits into the
// running magnitude. Status 1 flags a bad sign nibble (value 0), status 2 a
// magnitude past 2^63-1 (value saturated to +/-(2^63-1)). The input side
// stalls only while a finished result waits and the sink holds tready low.
// ----------------------------------------------------------------------------
module packed_zoned_decimal_decoder_unit
   import pzd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] action (0 packed, 1 zoned)
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata    // [63:0] value, [65:64] status, [71:66] zero
);

   logic            in_valid_ff;
   logic            in_zoned_ff;
   logic [7:0]      in_byte_ff;
   logic            in_last_ff;
   logic [MagW-1:0] acc_ff;
   logic [MagW-1:0] acc_in;
   logic            ovf_ff;
   logic            ovf_in;
   logic            rsp_valid_ff;
   logic [ValW-1:0] value_ff;
   logic [ValW-1:0] value_in;
   status_type      status_ff;
   status_type      status_in;
   logic [MagW-1:0] acc_nxt;
   logic            ovf_nxt;
   sign_info_type   sign_info;
   logic            out_free;
   logic            advance;
   logic [ValW-1:0] mag_w;

   // Accumulate datapath
   pzd_digit_acc u_acc (
      .acc       (acc_ff),
      .ovf       (ovf_ff),
      .zoned     (in_zoned_ff),
      .data_byte (in_byte_ff),
      .last_byte (in_last_ff),
      .acc_nxt   (acc_nxt),
      .ovf_nxt   (ovf_nxt)
   );

   // Sign decode
   pzd_sign_dec u_sign (
      .zoned     (in_zoned_ff),
      .data_byte (in_byte_ff),
      .sign_info (sign_info)
   );

   // Advance the held byte unless it is a last byte blocked by a full output
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && (!in_last_ff || out_free);
   assign req_tready = !in_valid_ff || advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_zoned_ff <= (req_tuser == ENC_ZONED);
         in_byte_ff  <= req_tdata;
         in_last_ff  <= req_tlast;
      end
   end

   // Next accumulator state: clear after the last byte of a field
   always_comb begin
      acc_in = acc_ff;
      ovf_in = ovf_ff;
      if (advance) begin
         if (in_last_ff) begin
            acc_in = '0;
            ovf_in = 1'b0;
         end else begin
            acc_in = acc_nxt;
            ovf_in = ovf_nxt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         acc_ff <= acc_in;
         ovf_ff <= ovf_in;
      end
   end

   // Form the signed result from the updated magnitude
   assign mag_w = {1'b0, acc_nxt};

   always_comb begin
      if (!sign_info.valid) begin
         value_in  = '0;
         status_in = ST_BAD_SIGN;
      end else begin
         value_in  = sign_info.minus ? (~mag_w + {{(ValW-1){1'b0}}, 1'b1}) : mag_w;
         status_in = ovf_nxt ? ST_OVERFLOW : ST_OK;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= advance && in_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && advance && in_last_ff) begin
         value_ff  <= value_in;
         status_ff <= status_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, status_ff, value_ff};

   // Saturated accumulator always sits at the maximum
   a_ovf_sat : assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> acc_ff == MAG_MAX)
      else $error("overflow flag set without saturated magnitude");

   // A field end clears the accumulator
   a_clear : assert property (@(posedge clock) disable iff (reset)
      advance && in_last_ff |=> acc_ff == '0 && !ovf_ff)
      else $error("accumulator not cleared after field end");

   // Bad sign yields a zero value
   a_bad_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff == ST_BAD_SIGN |-> value_ff == '0)
      else $error("bad sign result has nonzero value");

   // Overflow yields the saturated magnitude of either sign
   a_ovf_val : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff == ST_OVERFLOW |->
         value_ff == {1'b0, MAG_MAX} || value_ff == ~{1'b0, MAG_MAX} + 64'd1)
      else $error("overflow result not saturated");

endmodule
